// File: rtl/core/tfp_pkg.sv
// Package for the transaction frame parser: field and status codes, phase type, request types.
`timescale 1ns / 1ps
`default_nettype none
package tfp_pkg;

    localparam int unsigned MAX_MESSAGE_BYTES = 1024;
    localparam int unsigned TOTAL_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [7:0] WORD_BYTES = 8'd32;

    // field codes
    localparam logic [3:0] FC_SENDER   = 4'd0;
    localparam logic [3:0] FC_FEE      = 4'd1;
    localparam logic [3:0] FC_NONCE    = 4'd2;
    localparam logic [3:0] FC_VERSION  = 4'd3;
    localparam logic [3:0] FC_CHAIN    = 4'd4;
    localparam logic [3:0] FC_TO       = 4'd5;
    localparam logic [3:0] FC_SEL_LEN  = 4'd6;
    localparam logic [3:0] FC_SELECTOR = 4'd7;
    localparam logic [3:0] FC_COUNT    = 4'd8;
    localparam logic [3:0] FC_NAME_LEN = 4'd9;
    localparam logic [3:0] FC_NAME     = 4'd10;
    localparam logic [3:0] FC_ITEM     = 4'd11;
    localparam logic [3:0] FC_EXCESS   = 4'd12;

    // status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_WRONG_LENGTH = 4'd1;
    localparam logic [3:0] ST_SENDER       = 4'd2;
    localparam logic [3:0] ST_FEE          = 4'd3;
    localparam logic [3:0] ST_NONCE        = 4'd4;
    localparam logic [3:0] ST_VERSION      = 4'd5;
    localparam logic [3:0] ST_TO           = 4'd6;
    localparam logic [3:0] ST_SEL_LEN      = 4'd7;
    localparam logic [3:0] ST_SELECTOR     = 4'd8;
    localparam logic [3:0] ST_COUNT        = 4'd9;

    // parse phases, one-hot; the six fixed fields sit on consecutive bits
    typedef enum logic [13:0] {
        PH_SENDER   = 14'b00000000000001,
        PH_FEE      = 14'b00000000000010,
        PH_NONCE    = 14'b00000000000100,
        PH_VERSION  = 14'b00000000001000,
        PH_CHAIN    = 14'b00000000010000,
        PH_TO       = 14'b00000000100000,
        PH_SEL_LEN  = 14'b00000001000000,
        PH_SELECTOR = 14'b00000010000000,
        PH_COUNT    = 14'b00000100000000,
        PH_NAME_LEN = 14'b00001000000000,
        PH_NAME     = 14'b00010000000000,
        PH_ITEM     = 14'b00100000000000,
        PH_COMPLETE = 14'b01000000000000,
        PH_EXCESS   = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_req_t;

    typedef struct packed {
        logic [3:0] field_code;
        logic [7:0] byte_in_field;
        logic [7:0] entry_number;
        logic [7:0] echo_byte;
        logic       message_done;
        logic [3:0] status;
    } out_req_t;

endpackage
`default_nettype wire

// File: rtl/core/tfp_in_stage.sv
// Input register of the transaction frame parser.
`timescale 1ns / 1ps
`default_nettype none
module tfp_in_stage
    import tfp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire in_req_t load_req,
    input  wire logic    advance,
    output logic         stage_valid,
    output in_req_t      stage_req
);

    logic    valid_reg;
    logic    valid_next;
    in_req_t req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= load_req;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_req   = req_reg;

endmodule
`default_nettype wire

// File: rtl/core/tfp_parser.sv
// Parse state and per-byte tagging logic of the transaction frame parser.
`timescale 1ns / 1ps
`default_nettype none
module tfp_parser
    import tfp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire in_req_t req,
    output out_req_t     res
);

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [7:0]           cnt_reg;
    logic [7:0]           cnt_next;
    logic [7:0]           cnt_inc;
    logic [7:0]           len_reg;
    logic [7:0]           len_next;
    logic [7:0]           left_reg;
    logic [7:0]           left_next;
    logic [7:0]           left_dec;
    logic [7:0]           idx_reg;
    logic [7:0]           idx_next;
    logic [TOTAL_W-1:0]   total_reg;
    logic [TOTAL_W-1:0]   total_next;
    logic                 over_reg;
    logic                 over_next;
    logic                 total_sat;
    logic [3:0]           field_code;
    logic [3:0]           trunc_status;

    assign cnt_inc   = cnt_reg + 8'd1;
    assign left_dec  = left_reg - 8'd1;
    assign total_sat = (total_reg >= TOTAL_W'(MAX_MESSAGE_BYTES));
    assign total_next = total_sat ? total_reg : total_reg + TOTAL_W'(1);
    assign over_next  = over_reg | total_sat;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        unique case (phase_reg) inside
            PH_SENDER, PH_FEE, PH_NONCE, PH_VERSION, PH_CHAIN, PH_TO:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= WORD_BYTES)
                begin
                    cnt_next   = '0;
                    phase_next = phase_t'(phase_reg << 1);
                end
            end
            PH_SEL_LEN:
            begin
                len_next   = req.data_byte;
                cnt_next   = '0;
                phase_next = (req.data_byte != 8'd0) ? PH_SELECTOR : PH_COUNT;
            end
            PH_SELECTOR:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= len_reg)
                begin
                    cnt_next   = '0;
                    phase_next = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                left_next  = req.data_byte;
                idx_next   = '0;
                cnt_next   = '0;
                phase_next = (req.data_byte != 8'd0) ? PH_NAME_LEN : PH_COMPLETE;
            end
            PH_NAME_LEN:
            begin
                len_next   = req.data_byte;
                cnt_next   = '0;
                phase_next = (req.data_byte != 8'd0) ? PH_NAME : PH_ITEM;
            end
            PH_NAME:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= len_reg)
                begin
                    cnt_next   = '0;
                    phase_next = PH_ITEM;
                end
            end
            PH_ITEM:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= WORD_BYTES)
                begin
                    cnt_next   = '0;
                    left_next  = left_dec;
                    idx_next   = idx_reg + 8'd1;
                    phase_next = (left_dec != 8'd0) ? PH_NAME_LEN : PH_COMPLETE;
                end
            end
            PH_COMPLETE:
            begin
                cnt_next   = 8'd1;
                phase_next = PH_EXCESS;
            end
            PH_EXCESS:
            begin
                if (cnt_reg != 8'hFF)
                begin
                    cnt_next = cnt_inc;
                end
            end
            default:
            begin
                phase_next = PH_EXCESS;
            end
        endcase
    end

    // tag of the current byte
    always_comb
    begin
        unique case (phase_reg)
            PH_SENDER:   field_code = FC_SENDER;
            PH_FEE:      field_code = FC_FEE;
            PH_NONCE:    field_code = FC_NONCE;
            PH_VERSION:  field_code = FC_VERSION;
            PH_CHAIN:    field_code = FC_CHAIN;
            PH_TO:       field_code = FC_TO;
            PH_SEL_LEN:  field_code = FC_SEL_LEN;
            PH_SELECTOR: field_code = FC_SELECTOR;
            PH_COUNT:    field_code = FC_COUNT;
            PH_NAME_LEN: field_code = FC_NAME_LEN;
            PH_NAME:     field_code = FC_NAME;
            PH_ITEM:     field_code = FC_ITEM;
            default:     field_code = FC_EXCESS;
        endcase
    end

    // status if the message ends in the phase now open; chain reuses version
    always_comb
    begin
        unique case (phase_next)
            PH_SENDER:   trunc_status = ST_SENDER;
            PH_FEE:      trunc_status = ST_FEE;
            PH_NONCE:    trunc_status = ST_NONCE;
            PH_VERSION:  trunc_status = ST_VERSION;
            PH_CHAIN:    trunc_status = ST_VERSION;
            PH_TO:       trunc_status = ST_TO;
            PH_SEL_LEN:  trunc_status = ST_SEL_LEN;
            PH_SELECTOR: trunc_status = ST_SELECTOR;
            PH_COUNT:    trunc_status = ST_COUNT;
            PH_COMPLETE: trunc_status = ST_OK;
            default:     trunc_status = ST_WRONG_LENGTH;
        endcase
    end

    always_comb
    begin
        res.field_code    = field_code;
        res.byte_in_field = (phase_reg == PH_COMPLETE) ? 8'd0 : cnt_reg;
        res.entry_number  = (phase_reg == PH_NAME_LEN || phase_reg == PH_NAME ||
                             phase_reg == PH_ITEM) ? idx_reg : 8'd0;
        res.echo_byte     = req.data_byte;
        res.message_done  = req.last;
        res.status        = !req.last ? ST_OK :
                            (over_next ? ST_WRONG_LENGTH : trunc_status);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SENDER;
            cnt_reg   <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            idx_reg   <= '0;
            total_reg <= '0;
            over_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (req.last)
            begin
                phase_reg <= PH_SENDER;
                cnt_reg   <= '0;
                len_reg   <= '0;
                left_reg  <= '0;
                idx_reg   <= '0;
                total_reg <= '0;
                over_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                len_reg   <= len_next;
                left_reg  <= left_next;
                idx_reg   <= idx_next;
                total_reg <= total_next;
                over_reg  <= over_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/tfp_out_stage.sv
// Result register of the transaction frame parser.
`timescale 1ns / 1ps
`default_nettype none
module tfp_out_stage
    import tfp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire out_req_t load_res,
    input  wire logic     stall,
    output logic          ready,
    output logic          out_valid,
    output out_req_t      out_res
);

    logic     valid_reg;
    out_req_t res_reg;

    // free when empty or when the held result leaves this edge
    assign ready = !valid_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
`default_nettype wire

// File: rtl/core/transaction_frame_parser.sv
// Top level of the transaction frame parser: byte tagger and frame checker.
//
// Input channel: in_valid / in_stall carry one request per byte (data_byte, last).
// Output channel: out_valid / out_stall carry one tagged request per input byte:
// field_code, byte_in_field, entry_number, echo_byte, message_done, status.
// status is meaningful only with message_done and is zero otherwise.
// A request moves on a rising edge with valid high and stall low.
//
// Path from input accept to out_valid: the input register, then the parse logic
// feeding the result register. Throughput: one byte per cycle while the receiver
// does not stall; the parse state is a small phase machine plus byte and entry
// counters that update once per byte. When the receiver stalls, the held result
// stays put; at most one more byte is still taken into the input register, after
// which in_stall rises until the result register frees up.
// Reset (rst_n low, asynchronous) empties both registers and puts the parser
// in the sender phase with all counters at zero. After the last byte of a
// message the parser returns to that same state by itself.
`timescale 1ns / 1ps
`default_nettype none
module transaction_frame_parser
    import tfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [3:0]      field_code,
    output logic [7:0]      byte_in_field,
    output logic [7:0]      entry_number,
    output logic [7:0]      echo_byte,
    output logic            message_done,
    output logic [3:0]      status
);

    in_req_t  in_req;
    in_req_t  stage_req;
    logic     stage_valid;
    logic     out_ready;
    logic     advance;
    logic     in_load;
    out_req_t parse_res;
    out_req_t out_res;

    assign in_req.data_byte = data_byte;
    assign in_req.last      = last;

    // a byte leaves the input register when the result register can take it
    assign advance  = stage_valid && out_ready;
    assign in_stall = stage_valid && !out_ready;
    assign in_load  = in_valid && !in_stall;

    tfp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_load),
        .load_req    (in_req),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_req   (stage_req)
    );

    // parser state steps exactly once per byte handed to the result register
    tfp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (stage_req),
        .res   (parse_res)
    );

    tfp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (stage_valid),
        .load_res  (parse_res),
        .stall     (out_stall),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign field_code    = out_res.field_code;
    assign byte_in_field = out_res.byte_in_field;
    assign entry_number  = out_res.entry_number;
    assign echo_byte     = out_res.echo_byte;
    assign message_done  = out_res.message_done;
    assign status        = out_res.status;

    // status only reported on the last byte
    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !message_done |-> status == ST_OK)
        else $error("status set on a byte that is not last");

    // entry index shows only inside the entry list
    a_entry_scope: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_code != FC_NAME_LEN && field_code != FC_NAME &&
        field_code != FC_ITEM |-> entry_number == 8'd0)
        else $error("entry number outside entry fields");

    // a byte moved to the result register shows up there next cycle unchanged
    a_byte_passes: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid && echo_byte == $past(stage_req.data_byte) &&
        message_done == $past(stage_req.last))
        else $error("result register lost or altered a byte");

    // a valid result is never dropped while stalled
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled result dropped");

endmodule
`default_nettype wire

// File: tb/transaction_frame_parser_tb.sv
// Self-checking testbench for the transaction frame parser: random frames, stalls, byte predictor.
`timescale 1ns / 1ps
module transaction_frame_parser_tb
    import tfp_pkg::*;
();

    // Parser positions past the item field: frame complete, then bytes past it.
    localparam logic [3:0] FRAME_DONE    = 4'd12;
    localparam logic [3:0] FRAME_OVERRUN = 4'd13;

    // Cycles with no request moving on either side before the run is called hung.
    // Worst genuine quiet stretch is a result-side hold-off plus an input-side gap.
    localparam int IDLE_LIMIT = 5000;

    // Total input bytes for the run.
    localparam int ITEM_COUNT = 600;

    // Byte tagger and status predictor plus the queue of tags still owed by the block.
    class frame_book;
        out_req_t    tag_q[$];
        int          errors;
        logic [3:0]  phase;
        logic [7:0]  pos;
        logic [7:0]  span;
        logic [7:0]  remaining;
        logic [7:0]  entry;
        int unsigned seen;
        bit          oversize;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase     = FC_SENDER;
            pos       = 8'd0;
            span      = 8'd0;
            remaining = 8'd0;
            entry     = 8'd0;
            seen      = 0;
            oversize  = 1'b0;
        endfunction

        // status reported when the message stops with the parser sitting in ph
        function logic [3:0] cut_status(logic [3:0] ph);
            case (ph)
                FC_SENDER:   return ST_SENDER;
                FC_FEE:      return ST_FEE;
                FC_NONCE:    return ST_NONCE;
                FC_VERSION:  return ST_VERSION;
                FC_CHAIN:    return ST_VERSION;   // chain shares the version error
                FC_TO:       return ST_TO;
                FC_SEL_LEN:  return ST_SEL_LEN;
                FC_SELECTOR: return ST_SELECTOR;
                FC_COUNT:    return ST_COUNT;
                FRAME_DONE:  return ST_OK;
                default:     return ST_WRONG_LENGTH;
            endcase
        endfunction

        function int pending();
            return tag_q.size();
        endfunction

        function void note_request(logic [7:0] value, logic final_byte);
            out_req_t   t;
            logic [3:0] ph;
            ph = phase;
            t.field_code    = (ph >= FRAME_DONE) ? FC_EXCESS : ph;
            t.byte_in_field = (ph == FRAME_DONE) ? 8'd0 : pos;
            t.entry_number  = (ph >= FC_NAME_LEN && ph <= FC_ITEM) ? entry : 8'd0;
            t.echo_byte     = value;
            t.message_done  = final_byte;

            if (seen >= MAX_MESSAGE_BYTES)
                oversize = 1'b1;
            else
                seen++;

            case (ph)
                FC_SENDER, FC_FEE, FC_NONCE, FC_VERSION, FC_CHAIN, FC_TO:
                begin
                    pos++;
                    if (pos >= WORD_BYTES)
                    begin
                        pos = 8'd0;
                        ph++;
                    end
                end
                FC_SEL_LEN:
                begin
                    span = value;
                    pos  = 8'd0;
                    ph   = (value != 8'd0) ? FC_SELECTOR : FC_COUNT;
                end
                FC_SELECTOR:
                begin
                    pos++;
                    if (pos >= span)
                    begin
                        pos = 8'd0;
                        ph  = FC_COUNT;
                    end
                end
                FC_COUNT:
                begin
                    remaining = value;
                    entry     = 8'd0;
                    pos       = 8'd0;
                    ph        = (value != 8'd0) ? FC_NAME_LEN : FRAME_DONE;
                end
                FC_NAME_LEN:
                begin
                    span = value;
                    pos  = 8'd0;
                    ph   = (value != 8'd0) ? FC_NAME : FC_ITEM;
                end
                FC_NAME:
                begin
                    pos++;
                    if (pos >= span)
                    begin
                        pos = 8'd0;
                        ph  = FC_ITEM;
                    end
                end
                FC_ITEM:
                begin
                    pos++;
                    if (pos >= WORD_BYTES)
                    begin
                        pos = 8'd0;
                        remaining--;
                        entry++;
                        ph = (remaining != 8'd0) ? FC_NAME_LEN : FRAME_DONE;
                    end
                end
                FRAME_DONE:
                begin
                    pos = 8'd1;
                    ph  = FRAME_OVERRUN;
                end
                default:
                begin
                    if (pos < 8'd255)
                        pos++;
                    ph = FRAME_OVERRUN;
                end
            endcase
            phase = ph;

            if (final_byte)
                t.status = oversize ? ST_WRONG_LENGTH : cut_status(ph);
            else
                t.status = ST_OK;
            if (final_byte)
                clear();
            tag_q.push_back(t);
        endfunction

        function void compare(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_req_t got);
            out_req_t want;
            if (tag_q.size() == 0)
            begin
                $error("result with nothing outstanding: field_code %0d echo_byte %0d",
                       got.field_code, got.echo_byte);
                errors++;
                return;
            end
            want = tag_q.pop_front();
            compare("field_code", want.field_code, got.field_code);
            compare("byte_in_field", want.byte_in_field, got.byte_in_field);
            compare("entry_number", want.entry_number, got.entry_number);
            compare("echo_byte", want.echo_byte, got.echo_byte);
            compare("message_done", want.message_done, got.message_done);
            compare("status", want.status, got.status);
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] data_byte  = 8'd0;
    logic       last       = 1'b0;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [3:0] field_code;
    logic [7:0] byte_in_field;
    logic [7:0] entry_number;
    logic [7:0] echo_byte;
    logic       message_done;
    logic [3:0] status;

    frame_book  book = new();

    // message under construction and the name lengths of its entries
    logic [7:0] frame_bytes[$];
    int         name_lens[$];
    bit         burst = 1'b0;     // sender offers back to back while set
    int         sent_bytes = 0;
    int         results_seen = 0;
    int         hold_left = 0;
    int         free_left = 0;
    int         idle = 0;

    transaction_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .field_code    (field_code),
        .byte_in_field (byte_in_field),
        .entry_number  (entry_number),
        .echo_byte     (echo_byte),
        .message_done  (message_done),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly back to back, some short gaps, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_random_bytes(int n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endfunction

    // Well-formed frame: six 32-byte words, selector, then one entry per name_lens slot.
    function automatic void build_frame(int sel_len);
        frame_bytes.delete();
        add_random_bytes(192);
        frame_bytes.push_back(sel_len[7:0]);
        add_random_bytes(sel_len);
        frame_bytes.push_back(8'(name_lens.size()));
        foreach (name_lens[i])
        begin
            frame_bytes.push_back(name_lens[i][7:0]);
            add_random_bytes(name_lens[i]);
            add_random_bytes(32);
        end
    endfunction

    function automatic void pick_names(int max_count, int max_len);
        name_lens.delete();
        repeat ($urandom_range(0, max_count)) name_lens.push_back($urandom_range(0, max_len));
    endfunction

    // One request on the input channel; valid stays up across back-to-back requests.
    task automatic send_byte(logic [7:0] value, logic final_byte);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last      <= final_byte;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        book.note_request(value, final_byte);
    endtask

    // Sends the first keep bytes of the message under construction, last on the final one.
    task automatic send_message(int keep);
        for (int i = 0; i < keep; i++)
            send_byte(frame_bytes[i], i == keep - 1);
        sent_bytes += keep;
    endtask

    // Result side: check every accepted tag, then pick the next stall value.
    initial
    begin
        out_req_t got;
        int       r;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.field_code    = field_code;
                got.byte_in_field = byte_in_field;
                got.entry_number  = entry_number;
                got.echo_byte     = echo_byte;
                got.message_done  = message_done;
                got.status        = status;
                book.check_result(got);
                results_seen++;
                // long hold-offs while the sender keeps pushing: the block must back up
                if (results_seen == 50 || results_seen == 400)
                    hold_left = 200;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (free_left > 0)
            begin
                out_stall <= 1'b0;
                free_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                begin
                    free_left = $urandom_range(20, 100);
                    out_stall <= 1'b0;
                end
                else if (r < 70)
                    out_stall <= 1'b0;
                else
                begin
                    if (r < 92)
                        hold_left = $urandom_range(0, 2);
                    else if (r < 99)
                        hold_left = $urandom_range(3, 10);
                    else
                        hold_left = $urandom_range(20, 60);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // Hang detector: counts cycles in which no request moves on either channel.
    initial
    begin
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("transaction_frame_parser_tb: done, errors");
        $finish;
    end

    initial
    begin
        int kind;
        int keep;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-byte and tiny messages, byte extremes; all die in the sender word.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        sent_bytes += 7;

        // Truncation at the first word boundaries: the status names the next open field.
        name_lens.delete();
        for (int k = 1; k <= 2; k++)
        begin
            build_frame(0);
            send_message(32 * k);
        end
        // Shortest legal frame: zero selector, zero entries.
        build_frame(0);
        send_message(194);

        // Random mix: whole frames, frames cut short, frames with trailing bytes, noise.
        // The final message is cut to fit the byte budget.
        while (sent_bytes < ITEM_COUNT)
        begin
            burst = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 9);
            if (kind <= 7)
            begin
                pick_names(3, 4);
                build_frame($urandom_range(0, 6));
                if (kind <= 4)
                begin
                    if ($urandom_range(0, 2) == 0)
                        add_random_bytes($urandom_range(1, 5));
                    keep = frame_bytes.size();
                end
                else if ($urandom_range(0, 1) == 0)
                    keep = $urandom_range(193, frame_bytes.size());
                else
                    keep = $urandom_range(1, frame_bytes.size());
            end
            else
            begin
                frame_bytes.delete();
                add_random_bytes($urandom_range(1, 24));
                keep = frame_bytes.size();
            end
            if (keep > ITEM_COUNT - sent_bytes)
                keep = ITEM_COUNT - sent_bytes;
            send_message(keep);
        end

        burst = 1'b0;
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        // two-stage pipe; the extra wait flushes out anything unasked for
        repeat (10) @(posedge clk);

        if (book.errors == 0 && book.pending() == 0)
            $display("transaction_frame_parser_tb: done, clean");
        else
            $display("transaction_frame_parser_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/tfp_pkg.sv
rtl/core/tfp_in_stage.sv
rtl/core/tfp_parser.sv
rtl/core/tfp_out_stage.sv
rtl/core/transaction_frame_parser.sv
tb/transaction_frame_parser_tb.sv
